[rtl/asc_pkg.sv]
// Shared types and constants of the ASCII decimal line parser.
package asc_pkg;

    // Character codes that the parser recognises.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] DOT_RESET  = 8'd46;

    // Field widths of a result.
    localparam int MANT_W   = 31;
    localparam int MAG_W    = 30;
    localparam int FRAC_W   = 4;
    localparam int STATUS_W = 2;

    // Saturation limits of the magnitude and of the fraction digit count.
    localparam logic [MAG_W-1:0]  MAG_MAX  = 30'd999999999;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NAN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG = 2'd2;

    // Default line length limit.
    localparam int LINE_LIMIT_DEF = 10;

    // Depth of the queue between the classifier and the accumulator.
    localparam int Q_DEPTH = 2;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_DOT_CHAR = 1'b0;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic       newline;
        logic       nul;
        logic       minus;
        logic       sep;
        logic       digit;
        logic [3:0] dval;
    } char_class_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic        valid;
        char_class_t item;
    } q_head_t;

endpackage

[rtl/asc_if.sv]
// Valid/ready stream interfaces for characters and for parse results.
interface asc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface asc_result_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] mantissa;
    logic [3:0]         frac_digits;
    logic [1:0]         status;

    modport source (output valid, output mantissa, output frac_digits, output status,
                    input ready);
    modport sink (input valid, input mantissa, input frac_digits, input status,
                  output ready);
endinterface

[rtl/asc_front.sv]
// Front end: accepts characters and classifies them against the fixed codes and the separator code.
module asc_front (
    asc_char_if.sink            chars,
    input  logic [7:0]          dot_char,
    input  logic                q_full,
    output logic                push,
    output asc_pkg::char_class_t item
);
    import asc_pkg::*;

    // A character is taken whenever the queue has room.
    assign chars.ready = !q_full;
    assign push        = chars.valid && !q_full;

    // Classification; the back end applies the priority between the flags.
    always_comb
    begin
        item.newline = (chars.char_code == CH_NEWLINE);
        item.nul     = (chars.char_code == CH_NUL);
        item.minus   = (chars.char_code == CH_MINUS);
        item.sep     = (chars.char_code == dot_char);
        item.digit   = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
        item.dval    = chars.char_code[3:0];
    end

endmodule

[rtl/asc_queue.sv]
// Short queue of classified characters between the front and the back end.
module asc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  asc_pkg::char_class_t push_item,
    input  logic                 pop,
    output logic                 full,
    output asc_pkg::q_head_t     head
);
    import asc_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    char_class_t      mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(Q_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage is payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/asc_back.sv]
// Back end: accumulates the line state and registers one result per newline.
module asc_back #(
    parameter int LINE_LIMIT = asc_pkg::LINE_LIMIT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  asc_pkg::q_head_t head,
    output logic             pop,
    asc_result_if.source     results
);
    import asc_pkg::*;

    localparam int CNT_W = $clog2(LINE_LIMIT);

    // Line state.
    logic [MAG_W-1:0]  accum_reg, accum_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              seen_sep_reg, seen_sep_next;
    logic              neg_reg, neg_next;
    logic              bad_reg, bad_next;
    logic              ended_reg, ended_next;
    logic              long_reg, long_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic signed [MANT_W-1:0]   out_mant_reg, out_mant_next;
    logic [FRAC_W-1:0]          out_frac_reg, out_frac_next;
    logic [STATUS_W-1:0]        out_status_reg, out_status_next;

    logic [MAG_W+3:0] scaled;
    logic [MAG_W-1:0] accum_sat;
    logic             bad_final;
    char_class_t      it;

    assign it  = head.item;
    assign pop = head.valid && (!out_valid_reg || results.ready);

    // Multiply by ten as two shifts and add the new digit, saturating.
    assign scaled    = {accum_reg, 3'b000} + {2'b00, accum_reg, 1'b0} + (MAG_W + 4)'(it.dval);
    assign accum_sat = (scaled > (MAG_W + 4)'(MAG_MAX)) ? MAG_MAX : scaled[MAG_W-1:0];

    // A lone minus before the end of the text makes the line bad.
    assign bad_final = bad_reg || (!long_reg && !ended_reg && neg_reg && count_reg == CNT_W'(1));

    always_comb
    begin
        accum_next      = accum_reg;
        frac_next       = frac_reg;
        count_next      = count_reg;
        seen_sep_next   = seen_sep_reg;
        neg_next        = neg_reg;
        bad_next        = bad_reg;
        ended_next      = ended_reg;
        long_next       = long_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_mant_next   = out_mant_reg;
        out_frac_next   = out_frac_reg;
        out_status_next = out_status_reg;

        if (pop)
        begin
            if (it.newline)
            begin
                // Emit the result and clear the line.
                out_valid_next = 1'b1;
                out_mant_next  = '0;
                out_frac_next  = '0;
                if (long_reg)
                begin
                    out_status_next = ST_LONG;
                end
                else if (bad_final)
                begin
                    out_status_next = ST_NAN;
                end
                else
                begin
                    out_status_next = ST_OK;
                    out_frac_next   = frac_reg;
                    out_mant_next   = neg_reg ? MANT_W'(-{1'b0, accum_reg})
                                              : MANT_W'({1'b0, accum_reg});
                end
                accum_next    = '0;
                frac_next     = '0;
                count_next    = '0;
                seen_sep_next = 1'b0;
                neg_next      = 1'b0;
                bad_next      = 1'b0;
                ended_next    = 1'b0;
                long_next     = 1'b0;
            end
            else if (!long_reg)
            begin
                if (count_reg >= CNT_W'(LINE_LIMIT - 1))
                begin
                    long_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    if (!ended_reg)
                    begin
                        if (it.nul)
                        begin
                            ended_next = 1'b1;
                            if (neg_reg && count_reg == CNT_W'(1))
                            begin
                                bad_next = 1'b1;
                            end
                        end
                        else if (count_reg == '0 && it.minus)
                        begin
                            neg_next = 1'b1;
                        end
                        else if (it.sep)
                        begin
                            if (seen_sep_reg)
                            begin
                                bad_next = 1'b1;
                            end
                            seen_sep_next = 1'b1;
                        end
                        else if (it.digit)
                        begin
                            accum_next = accum_sat;
                            if (seen_sep_reg && frac_reg < FRAC_MAX)
                            begin
                                frac_next = frac_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= '0;
            frac_reg      <= '0;
            count_reg     <= '0;
            seen_sep_reg  <= 1'b0;
            neg_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            ended_reg     <= 1'b0;
            long_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg     <= accum_next;
            frac_reg      <= frac_next;
            count_reg     <= count_next;
            seen_sep_reg  <= seen_sep_next;
            neg_reg       <= neg_next;
            bad_reg       <= bad_next;
            ended_reg     <= ended_next;
            long_reg      <= long_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_mant_reg   <= out_mant_next;
        out_frac_reg   <= out_frac_next;
        out_status_reg <= out_status_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.mantissa    = out_mant_reg;
    assign results.frac_digits = out_frac_reg;
    assign results.status      = out_status_reg;

endmodule

[rtl/ascii_decimal_line_parser.sv]
// Top level of the ASCII decimal line parser.
//
// Characters arrive on the chars stream, one per transfer, and one result
// leaves on the results stream for every newline: a signed mantissa, the
// number of fraction digits and a status (ok, not a number, line too long).
// The separator code is an APB register at byte address 0, reset to '.';
// it must be written by the user only while no line is in flight; the block itself does not enforce this.
//
// A character is classified as it is taken, waits in a two-entry queue and
// is folded into the line state by the accumulator when the output register
// is empty or its result is being taken; the result of a newline is loaded
// into the output register as that newline is folded in.
// Throughput is one character per cycle while the receiver does not stall,
// set by the combinational multiply-by-ten-and-add in the accumulator.
//
// Reset clears the line state, empties the queue and drops any pending
// result. When the receiver stalls, the result waits in the output
// register, the queue fills and chars.ready falls once it is full.
module ascii_decimal_line_parser #(
    parameter int LINE_LIMIT = asc_pkg::LINE_LIMIT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [asc_pkg::APB_AW-1:0] paddr,
    input  logic [asc_pkg::APB_DW-1:0] pwdata,
    output logic [asc_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    asc_char_if.sink                   chars,
    asc_result_if.source               results
);
    import asc_pkg::*;

    logic [7:0]  dot_char_reg, dot_char_next;
    logic        cfg_wr;
    logic        push;
    logic        q_full;
    logic        pop;
    char_class_t push_item;
    q_head_t     head;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DOT_CHAR);
    assign dot_char_next = cfg_wr ? pwdata[7:0] : dot_char_reg;
    assign prdata = (paddr[2] == REG_DOT_CHAR) ? APB_DW'(dot_char_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_char_reg <= DOT_RESET;
        end
        else
        begin
            dot_char_reg <= dot_char_next;
        end
    end

    asc_front u_front (
        .chars    (chars),
        .dot_char (dot_char_reg),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    asc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .head      (head)
    );

    asc_back #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

`ifndef SYNTHESIS
    // The status is always one of the three defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.status == ST_OK || results.status == ST_NAN ||
                           results.status == ST_LONG))
        else $error("result status code undefined");

    // A failed line carries a zero mantissa and no fraction digits.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status != ST_OK) |->
            (results.mantissa == '0 && results.frac_digits == '0))
        else $error("failed result carries a value");

    // A good mantissa never exceeds the saturated magnitude.
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status == ST_OK) |->
            (results.mantissa <= 31'sd999999999 && results.mantissa >= -31'sd999999999))
        else $error("mantissa out of range");

    // The queue is never popped while it is empty.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");
`endif

endmodule

[tb/line_result_checker.sv]
// Checker of the line parser: predicts every parse result and separator read-back and compares them with the block.
module line_result_checker
    import asc_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic [APB_DW-1:0] prdata,
    input  logic              pready,
    asc_char_if               chars,
    asc_result_if             results,
    output int                results_owed,
    output int                mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_AW-1:0] DOT_CHAR_ADDR = {REG_DOT_CHAR, 2'b00};

    // One parse result as the block should emit it.
    typedef struct packed {
        logic signed [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0]        frac_digits;
        logic [STATUS_W-1:0]      status;
    } number_t;

    number_t expected_numbers [$];

    // Shadow copy of the separator register and of the line being parsed.
    logic [7:0]        sep_code   = DOT_RESET;
    logic [MAG_W-1:0]  magnitude  = '0;
    logic [FRAC_W-1:0] frac_count = '0;
    int                line_len   = 0;
    logic              sep_seen   = 1'b0;
    logic              negative   = 1'b0;
    logic              bad_chars  = 1'b0;
    logic              text_done  = 1'b0;
    logic              too_long   = 1'b0;
    int                mismatches = 0;

    function automatic void clear_line_state();
        magnitude  = '0;
        frac_count = '0;
        line_len   = 0;
        sep_seen   = 1'b0;
        negative   = 1'b0;
        bad_chars  = 1'b0;
        text_done  = 1'b0;
        too_long   = 1'b0;
    endfunction

    // Folds one character other than newline into the line state.
    function automatic void parse_char(input logic [7:0] c);
        int         pos;
        logic [63:0] grown;
        pos = line_len;
        if (too_long)
            return;
        // Characters at and past the limit only mark the line as too long.
        if (pos >= LINE_LIMIT - 1)
        begin
            too_long = 1'b1;
            return;
        end
        line_len = pos + 1;
        if (text_done)
            return;
        if (c == CH_NUL)
        begin
            // A zero byte ends the text; a minus standing alone is not a number.
            text_done = 1'b1;
            if (negative && pos == 1)
                bad_chars = 1'b1;
        end
        else if (pos == 0 && c == CH_MINUS)
        begin
            negative = 1'b1;
        end
        else if (c == sep_code)
        begin
            if (sep_seen)
                bad_chars = 1'b1;
            sep_seen = 1'b1;
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            grown = 64'(magnitude) * 64'd10 + 64'(c - CH_ZERO);
            magnitude = (grown > 64'(MAG_MAX)) ? MAG_MAX : grown[MAG_W-1:0];
            if (sep_seen && frac_count < FRAC_MAX)
                frac_count = frac_count + 1'b1;
        end
        else
        begin
            bad_chars = 1'b1;
        end
    endfunction

    // Works out the result that a newline produces and starts a fresh line.
    function automatic number_t close_line();
        number_t n;
        if (!too_long && !text_done && negative && line_len == 1)
            bad_chars = 1'b1;
        n = '0;
        if (too_long)
            n.status = ST_LONG;
        else if (bad_chars)
            n.status = ST_NAN;
        else
        begin
            n.status      = ST_OK;
            n.mantissa    = negative ? -{1'b0, magnitude} : {1'b0, magnitude};
            n.frac_digits = frac_count;
        end
        clear_line_state();
        return n;
    endfunction

    function automatic void compare_field(input string field, input integer want,
                                          input integer got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Watch the register port and both streams at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        number_t want;
        if (!rst_n)
        begin
            sep_code = DOT_RESET;
            clear_line_state();
            expected_numbers.delete();
        end
        else
        begin
            // Register writes update the shadow copy; reads must return it.
            if (psel && penable && pready && paddr == DOT_CHAR_ADDR)
            begin
                if (pwrite)
                    sep_code = pwdata[7:0];
                else
                    compare_field("separator read-back", sep_code, prdata[7:0]);
            end

            // Character transfer: newline closes the line and owes a result.
            if (chars.valid && chars.ready)
            begin
                if (chars.char_code == CH_NEWLINE)
                    expected_numbers.push_back(close_line());
                else
                    parse_char(chars.char_code);
            end

            // Result transfer: compare against the oldest expectation.
            if (results.valid && results.ready)
            begin
                if (expected_numbers.size() == 0)
                begin
                    $display("%0t: result with none expected: mantissa %0d frac %0d status %0d",
                             $time, results.mantissa, results.frac_digits, results.status);
                    mismatches++;
                end
                else
                begin
                    want = expected_numbers.pop_front();
                    compare_field("mantissa", want.mantissa, results.mantissa);
                    compare_field("frac_digits", want.frac_digits, results.frac_digits);
                    compare_field("status", want.status, results.status);
                end
            end
        end
        results_owed   <= expected_numbers.size();
        mismatch_count <= mismatches;
    end

endmodule

[tb/tb_top.sv]
// Top of the line parser testbench: clock, reset, stimulus, register writes and verdict.
module tb_top
    import asc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LIMIT      = LINE_LIMIT_DEF;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int PHASES          = 7;
    localparam int HOLD_CYCLES     = 120;
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam logic [APB_AW-1:0] DOT_CHAR_ADDR = {REG_DOT_CHAR, 2'b00};

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    asc_char_if   chars_if ();
    asc_result_if results_if ();

    int         results_owed;
    int         mismatch_count;
    logic [7:0] line_buf [$];
    logic [7:0] sep_now      = DOT_RESET;
    logic       calm         = 1'b0;
    logic       hold_req     = 1'b0;
    int         quiet_cycles = 0;
    int         chars_sent   = 0;

    ascii_decimal_line_parser #(
        .LINE_LIMIT(LINE_LIMIT)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .chars   (chars_if),
        .results (results_if)
    );

    line_result_checker #(
        .LINE_LIMIT(LINE_LIMIT)
    ) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .chars          (chars_if),
        .results        (results_if),
        .results_owed   (results_owed),
        .mismatch_count (mismatch_count)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: too long without any transfer or register access ends the run.
    always @(posedge clk)
    begin
        if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ascii_decimal_line_parser regression: fail");
            $finish;
        end
    end

    // Result side: random stretches of ready and stall, plus one long hold-off.
    initial
    begin : result_receiver
        int   span;
        int   pick;
        logic hold_taken;
        span       = 0;
        hold_taken = 1'b0;
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                // The block has to fill up and stall its input during this hold.
                hold_taken = 1'b1;
                results_if.ready <= 1'b0;
                span = HOLD_CYCLES;
            end
            else if (span == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    results_if.ready <= 1'b1;
                    span = (pick < 10) ? $urandom_range(20, 60) : $urandom_range(1, 8);
                end
                else
                begin
                    results_if.ready <= 1'b0;
                    span = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 30);
                end
            end
            @(posedge clk);
            span--;
        end
    end

    // Gap before a character: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Offers one character and holds it until the transfer takes place.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= c;
        do
            @(posedge clk);
        while (!chars_if.ready);
        chars_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Sends the buffered line followed by its newline.
    task automatic send_line();
        line_buf.push_back(CH_NEWLINE);
        foreach (line_buf[i])
            send_char(line_buf[i]);
        line_buf.delete();
    endtask

    // Stops offering, waits for every owed result, then lets the pipeline empty.
    task automatic settle();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure_separator(input logic [7:0] code);
        apb_access(1'b1, DOT_CHAR_ADDR, {24'd0, code});
        @(posedge clk);
        apb_access(1'b0, DOT_CHAR_ADDR, '0);
        sep_now = code;
    endtask

    // Builds one random line in line_buf, without its newline.
    task automatic build_random_line();
        int         kind;
        int         ndig;
        int         seppos;
        int         spot;
        logic       neg;
        logic       has_sep;
        logic       nines;
        logic [7:0] junk;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 90)
        begin
            // Noise: bytes of any value, stray newlines included.
            repeat ($urandom_range(0, LINE_LIMIT + 2))
                line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end

        // A well-formed number first; some kinds then spoil or stretch it.
        neg     = ($urandom_range(0, 3) == 0);
        has_sep = ($urandom_range(0, 2) != 0);
        nines   = ($urandom_range(0, 5) == 0);
        if (kind >= 60 && kind < 70)
            ndig = $urandom_range(LINE_LIMIT - 2, LINE_LIMIT + 3);
        else
            ndig = $urandom_range(0, LINE_LIMIT - 1 - int'(neg) - int'(has_sep));
        seppos = $urandom_range(0, ndig);
        if (neg)
            line_buf.push_back(CH_MINUS);
        for (int i = 0; i <= ndig; i++)
        begin
            if (has_sep && i == seppos)
                line_buf.push_back(sep_now);
            if (i < ndig)
                line_buf.push_back(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
        end

        if (kind >= 70 && kind < 80)
        begin
            // Zero byte part-way, then characters that only count towards the length.
            spot = $urandom_range(0, line_buf.size());
            line_buf.insert(spot, CH_NUL);
            repeat ($urandom_range(0, 3))
            begin
                junk = 8'($urandom_range(0, 255));
                line_buf.push_back((junk == CH_NEWLINE) ? CH_NUL : junk);
            end
        end
        else if (kind >= 80 && kind < 90)
        begin
            // Broken number: an extra separator, a misplaced minus or a stray byte.
            spot = $urandom_range(0, line_buf.size());
            junk = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0:       line_buf.insert(spot, sep_now);
                1:       line_buf.insert(spot, CH_MINUS);
                default: line_buf.insert(spot, (junk == CH_NEWLINE) ? 8'hFF : junk);
            endcase
        end
    endtask

    // Main sequence: reset, directed lines, then random phases per separator.
    initial
    begin : stimulus
        logic [7:0] phase_seps [PHASES];
        chars_if.valid     <= 1'b0;
        chars_if.char_code <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Separator must read back as its reset value before any write.
        apb_access(1'b0, DOT_CHAR_ADDR, '0);

        // Directed lines with the default separator.
        send_line();
        add_text("-");
        send_line();
        add_text("5");
        line_buf.push_back(CH_NUL);
        add_text("?");
        send_line();
        add_text("-.");
        send_line();
        add_text("1..");
        send_line();
        add_text("3-");
        line_buf.push_back(8'hFF);
        send_line();
        add_text("0123456789");
        send_line();
        settle();

        // Separator settings: ordinary, zero, all ones, a digit, minus, default, random.
        phase_seps = '{8'd44, CH_NUL, 8'hFF, CH_ZERO + 8'd5, CH_MINUS, DOT_RESET, 8'd0};
        phase_seps[PHASES-1] = 8'($urandom_range(0, 255));
        for (int phase = 0; phase < PHASES; phase++)
        begin
            configure_separator(phase_seps[phase]);
            chars_sent = 0;
            if (phase == 0)
            begin
                // Keep offering lines while the receiver holds off.
                hold_req <= 1'b1;
                calm = 1'b1;
                repeat (12)
                begin
                    build_random_line();
                    send_line();
                end
            end
            while (chars_sent < ITEMS_PER_PHASE)
            begin
                calm = ($urandom_range(0, 7) == 0);
                build_random_line();
                send_line();
            end
            calm = 1'b0;
            settle();
        end

        if (mismatch_count == 0)
            $display("ascii_decimal_line_parser regression: pass");
        else
            $display("ascii_decimal_line_parser regression: fail");
        $finish;
    end

endmodule

[ascii_decimal_line_parser.f]
rtl/asc_pkg.sv
rtl/asc_if.sv
rtl/asc_front.sv
rtl/asc_queue.sv
rtl/asc_back.sv
rtl/ascii_decimal_line_parser.sv
tb/line_result_checker.sv
tb/tb_top.sv
